// ----- src/spvc_pkg.sv -----
// Package for the solar pump and valve controller.
// Holds the shared types, register indexes, mode codes and constants.
// Depends on nothing; every other file in src uses it by scoped names.
package spvc_pkg;

  // Width of the shared adder. It holds a 32-bit unsigned value with headroom.
  localparam int AluW = 34;
  localparam int TempW = 16;
  localparam int DutyW = 7;
  localparam int LevelW = 8;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 16;
  localparam int TimeW = 32;
  localparam int MulAW = 14;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;
  localparam int DivSteps = 7;
  localparam int DivCountW = 3;

  localparam logic [TimeW-1:0] LowFlowSeconds = 32'd1800;
  localparam logic [AluW-1:0] ReverseGuardRise = 34'd60;
  localparam logic [DutyW-1:0] DutyLimit = 7'd100;

  // Level = duty * 255 / 100, done as a multiply by 255 and then a multiply
  // by the rounded-up reciprocal of 100 scaled by 2^19, exact for duty <= 100.
  localparam logic [MulBW-1:0] LevelScale = 18'd255;
  localparam logic [MulAW-1:0] LevelRecip = 14'd5243;
  localparam int LevelShift = 19;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegCritical = 3'd0;
  localparam logic [CfgIndexW-1:0] RegTankLimit = 3'd1;
  localparam logic [CfgIndexW-1:0] RegStartRise = 3'd2;
  localparam logic [CfgIndexW-1:0] RegLowRise = 3'd3;
  localparam logic [CfgIndexW-1:0] RegFullRise = 3'd4;
  localparam logic [CfgIndexW-1:0] RegMinDuty = 3'd5;
  localparam logic [CfgIndexW-1:0] RegMaxDuty = 3'd6;

  typedef logic signed [AluW-1:0] alu_word_t;

  typedef enum logic [2:0] {
    MODE_CRITICAL = 3'd0,
    MODE_REVERSE  = 3'd1,
    MODE_REGULATE = 3'd2,
    MODE_LOW_FLOW = 3'd3,
    MODE_EXPIRED  = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [TempW-1:0] critical_collector_temp;
    logic signed [TempW-1:0] tank_limit_temp;
    logic signed [TempW-1:0] start_rise;
    logic signed [TempW-1:0] low_rise;
    logic signed [TempW-1:0] full_rise;
    logic [DutyW-1:0]        min_duty;
    logic [DutyW-1:0]        max_duty;
  } cfg_t;

  // Duty registers take the low seven bits and saturate at 100 percent.
  function automatic logic [DutyW-1:0] sat_duty(input logic [CfgDataW-1:0] value);
    logic [DutyW-1:0] low_bits;
    low_bits = value[DutyW-1:0];
    return (low_bits > DutyLimit) ? DutyLimit : low_bits;
  endfunction

endpackage

// ----- src/spvc_alu.sv -----
// Shared add and subtract unit of the solar pump and valve controller.
// Every sum and every temperature or time compare of the sequencer goes through it, one per cycle.
// Depends on spvc_pkg.
module spvc_alu (
  input  spvc_pkg::alu_word_t a,
  input  spvc_pkg::alu_word_t b,
  input  logic                sub,
  output spvc_pkg::alu_word_t res,
  output logic                neg
);

  assign res = sub ? (a - b) : (a + b);
  // Operands are narrower than the word, so the sign of a difference is exact.
  assign neg = res[spvc_pkg::AluW-1];

endmodule

// ----- src/spvc_mul.sv -----
// Shared signed multiplier of the solar pump and valve controller, with the
// product registered. Used for the interpolation numerator and the level.
// Depends on spvc_pkg.
module spvc_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [spvc_pkg::MulAW-1:0]    a,
  input  logic signed [spvc_pkg::MulBW-1:0]    b,
  output logic signed [spvc_pkg::MulPW-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ----- src/spvc_cfg.sv -----
// Configuration registers of the solar pump and valve controller.
// Decodes the write port and saturates the duty limits on write.
// Depends on spvc_pkg.
module spvc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [spvc_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [spvc_pkg::CfgDataW-1:0]     cfg_data,
  output spvc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.critical_collector_temp <= 16'sd9000;
      cfg.tank_limit_temp <= 16'sd6000;
      cfg.start_rise <= 16'sd800;
      cfg.low_rise <= 16'sd300;
      cfg.full_rise <= 16'sd1500;
      cfg.min_duty <= 7'd20;
      cfg.max_duty <= 7'd100;
    end else if (cfg_write) begin
      case (cfg_index)
        spvc_pkg::RegCritical:  cfg.critical_collector_temp <= cfg_data;
        spvc_pkg::RegTankLimit: cfg.tank_limit_temp <= cfg_data;
        spvc_pkg::RegStartRise: cfg.start_rise <= cfg_data;
        spvc_pkg::RegLowRise:   cfg.low_rise <= cfg_data;
        spvc_pkg::RegFullRise:  cfg.full_rise <= cfg_data;
        spvc_pkg::RegMinDuty:   cfg.min_duty <= spvc_pkg::sat_duty(cfg_data);
        spvc_pkg::RegMaxDuty:   cfg.max_duty <= spvc_pkg::sat_duty(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/solar_pump_valve_controller_unit.sv -----
// Solar pump and valve controller. One input word (four temperatures in
// hundredths of a degree and a seconds timestamp) gives one result word with
// pump, switch, duty, valve level and mode. A word passes through the states
// of the sequencer from acceptance to a registered result, on a shorter path
// for a critical or tank-full stop than when it interpolates; the path is set by
// the single shared adder, which serves one compare or sum per cycle, and by
// the seven-step restoring divider for the duty quotient. The input is ready
// again the cycle after a result is registered; a result waits in its output
// register while the next word is processed. Configuration writes take effect
// at once and are meant for when the block is idle.
module solar_pump_valve_controller_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                collector_temp,
  input  logic signed [15:0]                tank_temp,
  input  logic signed [15:0]                inlet_temp,
  input  logic signed [15:0]                outlet_temp,
  input  logic [31:0]                       time_seconds,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              pump_on,
  output logic                              switch_on,
  output logic [6:0]                        duty_percent,
  output logic [7:0]                        valve_level,
  output logic [2:0]                        mode,
  input  logic                              cfg_write,
  input  logic [spvc_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [spvc_pkg::CfgDataW-1:0]     cfg_data
);

  typedef enum logic [23:0] {
    ST_IDLE      = 24'h000001,
    ST_CRIT      = 24'h000002,
    ST_TANK      = 24'h000004,
    ST_REV_DIFF  = 24'h000008,
    ST_REV_RISE  = 24'h000010,
    ST_REV_CMP   = 24'h000020,
    ST_START     = 24'h000040,
    ST_SUM       = 24'h000080,
    ST_AVG       = 24'h000100,
    ST_DT        = 24'h000200,
    ST_LOW       = 24'h000400,
    ST_FULL      = 24'h000800,
    ST_SPAN      = 24'h001000,
    ST_MUL_BASE  = 24'h002000,
    ST_MUL_RISE  = 24'h004000,
    ST_NUM       = 24'h008000,
    ST_DIV       = 24'h010000,
    ST_CLAMP     = 24'h020000,
    ST_LF_CMP    = 24'h040000,
    ST_LF_DELTA  = 24'h080000,
    ST_LF_ACC    = 24'h100000,
    ST_LVL_SCALE = 24'h200000,
    ST_LVL_DIV   = 24'h400000,
    ST_OUT       = 24'h800000
  } state_t;

  state_t state, state_next;

  spvc_pkg::cfg_t cfg;

  // Latched input word.
  logic signed [15:0] col;
  logic signed [15:0] tank;
  logic signed [15:0] inl;
  logic signed [15:0] outl;
  logic [31:0]        now;

  // Controller state.
  logic               pump_running;
  logic               switch_state;
  logic [6:0]         duty;
  logic [31:0]        low_flow_elapsed;
  logic [31:0]        last_run_time;
  spvc_pkg::mode_t    mode_q;

  // Working registers of the sequencer.
  logic                     crit_hit;
  logic signed [17:0]       col_rise;
  spvc_pkg::alu_word_t      tmp;
  logic signed [17:0]       dlow;
  logic signed [17:0]       span;
  logic signed [7:0]        duty_diff;
  spvc_pkg::alu_word_t      num;
  logic [6:0]               quot;
  logic [spvc_pkg::DivCountW-1:0] div_count;

  // Shared units.
  spvc_pkg::alu_word_t      alu_a;
  spvc_pkg::alu_word_t      alu_b;
  logic                     alu_sub;
  spvc_pkg::alu_word_t      alu_res;
  logic                     alu_neg;
  logic                     mul_en;
  logic signed [spvc_pkg::MulAW-1:0] mul_a;
  logic signed [spvc_pkg::MulBW-1:0] mul_b;
  logic signed [spvc_pkg::MulPW-1:0] prod;

  logic avg_round;
  logic out_free;

  spvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spvc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .neg (alu_neg)
  );

  spvc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  // The average truncates toward zero: a negative odd sum is bumped by one.
  assign avg_round = tmp[spvc_pkg::AluW-1] & tmp[0];

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b1;
    case (state)
      ST_CRIT: begin
        alu_a = spvc_pkg::alu_word_t'(col);
        alu_b = spvc_pkg::alu_word_t'(cfg.critical_collector_temp);
      end
      ST_TANK: begin
        alu_a = spvc_pkg::alu_word_t'(cfg.tank_limit_temp);
        alu_b = spvc_pkg::alu_word_t'(tank);
      end
      ST_REV_DIFF: begin
        alu_a = spvc_pkg::alu_word_t'(col);
        alu_b = spvc_pkg::alu_word_t'(outl);
      end
      ST_REV_RISE: begin
        alu_a = spvc_pkg::alu_word_t'(inl);
        alu_b = spvc_pkg::alu_word_t'(outl);
      end
      ST_REV_CMP: begin
        alu_a = tmp;
        alu_b = spvc_pkg::ReverseGuardRise;
      end
      ST_START: begin
        alu_a = spvc_pkg::alu_word_t'(cfg.start_rise);
        alu_b = spvc_pkg::alu_word_t'(col_rise);
      end
      ST_SUM: begin
        alu_a = spvc_pkg::alu_word_t'(col);
        alu_b = spvc_pkg::alu_word_t'(inl);
        alu_sub = 1'b0;
      end
      ST_AVG: begin
        alu_a = tmp;
        alu_b = spvc_pkg::alu_word_t'({1'b0, avg_round});
        alu_sub = 1'b0;
      end
      ST_DT: begin
        alu_a = tmp;
        alu_b = spvc_pkg::alu_word_t'(outl);
      end
      ST_LOW: begin
        alu_a = tmp;
        alu_b = spvc_pkg::alu_word_t'(cfg.low_rise);
      end
      ST_FULL: begin
        alu_a = tmp;
        alu_b = spvc_pkg::alu_word_t'(cfg.full_rise);
      end
      ST_SPAN: begin
        alu_a = spvc_pkg::alu_word_t'(cfg.full_rise);
        alu_b = spvc_pkg::alu_word_t'(cfg.low_rise);
      end
      ST_MUL_BASE: begin
        alu_a = spvc_pkg::alu_word_t'({1'b0, cfg.max_duty});
        alu_b = spvc_pkg::alu_word_t'({1'b0, cfg.min_duty});
      end
      ST_NUM: begin
        alu_a = num;
        alu_b = spvc_pkg::alu_word_t'(prod);
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = num;
        alu_b = spvc_pkg::alu_word_t'(span) << div_count;
      end
      ST_LF_CMP: begin
        alu_a = spvc_pkg::alu_word_t'({1'b0, low_flow_elapsed});
        alu_b = spvc_pkg::alu_word_t'({1'b0, spvc_pkg::LowFlowSeconds});
      end
      ST_LF_DELTA: begin
        alu_a = spvc_pkg::alu_word_t'({1'b0, now});
        alu_b = spvc_pkg::alu_word_t'({1'b0, last_run_time});
      end
      ST_LF_ACC: begin
        alu_a = spvc_pkg::alu_word_t'({1'b0, low_flow_elapsed});
        alu_b = tmp;
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_BASE: begin
        mul_en = 1'b1;
        mul_a = spvc_pkg::MulAW'(signed'({1'b0, cfg.min_duty}));
        mul_b = span;
      end
      ST_MUL_RISE: begin
        mul_en = 1'b1;
        mul_a = spvc_pkg::MulAW'(duty_diff);
        mul_b = dlow;
      end
      ST_LVL_SCALE: begin
        mul_en = 1'b1;
        mul_a = spvc_pkg::MulAW'(signed'({1'b0, duty}));
        mul_b = spvc_pkg::LevelScale;
      end
      ST_LVL_DIV: begin
        mul_en = 1'b1;
        mul_a = spvc_pkg::LevelRecip;
        mul_b = {1'b0, prod[spvc_pkg::MulBW-2:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CRIT;
      ST_CRIT:      state_next = ST_TANK;
      ST_TANK:      state_next = (crit_hit || alu_neg) ? ST_LVL_SCALE : ST_REV_DIFF;
      ST_REV_DIFF:  state_next = ST_REV_RISE;
      ST_REV_RISE:  state_next = ST_REV_CMP;
      ST_REV_CMP: begin
        state_next = (col_rise[17] && alu_neg) ? ST_LVL_SCALE : ST_START;
      end
      ST_START:     state_next = ST_SUM;
      ST_SUM:       state_next = ST_AVG;
      ST_AVG:       state_next = ST_DT;
      ST_DT:        state_next = ST_LOW;
      ST_LOW: begin
        if (alu_neg) begin
          state_next = ST_LF_CMP;
        end else if (pump_running) begin
          state_next = ST_FULL;
        end else begin
          state_next = ST_LVL_SCALE;
        end
      end
      ST_FULL:      state_next = alu_neg ? ST_SPAN : ST_LVL_SCALE;
      ST_SPAN:      state_next = ST_MUL_BASE;
      ST_MUL_BASE:  state_next = ST_MUL_RISE;
      ST_MUL_RISE:  state_next = ST_NUM;
      ST_NUM:       state_next = ST_DIV;
      ST_DIV:       if (div_count == '0) state_next = ST_CLAMP;
      ST_CLAMP:     state_next = ST_LVL_SCALE;
      ST_LF_CMP:    state_next = alu_neg ? ST_LF_DELTA : ST_LVL_SCALE;
      ST_LF_DELTA:  state_next = ST_LF_ACC;
      ST_LF_ACC:    state_next = ST_LVL_SCALE;
      ST_LVL_SCALE: state_next = ST_LVL_DIV;
      ST_LVL_DIV:   state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pump_running <= 1'b0;
      switch_state <= 1'b0;
      duty <= '0;
      low_flow_elapsed <= '0;
      last_run_time <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            col <= collector_temp;
            tank <= tank_temp;
            inl <= inlet_temp;
            outl <= outlet_temp;
            now <= time_seconds;
          end
        end
        ST_CRIT: crit_hit <= !alu_neg;
        ST_TANK: begin
          if (crit_hit || alu_neg) begin
            pump_running <= 1'b0;
            switch_state <= 1'b0;
            duty <= '0;
            mode_q <= spvc_pkg::MODE_CRITICAL;
          end
        end
        ST_REV_DIFF: col_rise <= alu_res[17:0];
        ST_REV_RISE: tmp <= alu_res;
        ST_REV_CMP: begin
          // Outlet above collector with too small a loop rise: flow is reversing.
          if (col_rise[17] && alu_neg) begin
            pump_running <= 1'b0;
            switch_state <= 1'b0;
            duty <= '0;
            mode_q <= spvc_pkg::MODE_REVERSE;
          end
        end
        ST_START: begin
          if (alu_neg) begin
            pump_running <= 1'b1;
            switch_state <= 1'b1;
            low_flow_elapsed <= '0;
          end
        end
        ST_SUM: tmp <= alu_res;
        ST_AVG: tmp <= alu_res >>> 1;
        ST_DT:  tmp <= alu_res;
        ST_LOW: begin
          dlow <= alu_res[17:0];
          if (!alu_neg) begin
            mode_q <= spvc_pkg::MODE_REGULATE;
          end
        end
        ST_FULL: if (!alu_neg) duty <= cfg.max_duty;
        ST_SPAN: span <= alu_res[17:0];
        ST_MUL_BASE: duty_diff <= alu_res[7:0];
        ST_MUL_RISE: num <= spvc_pkg::alu_word_t'(prod);
        ST_NUM: begin
          num <= alu_res;
          quot <= '0;
          div_count <= spvc_pkg::DivCountW'(spvc_pkg::DivSteps - 1);
        end
        ST_DIV: begin
          // Restoring division: the quotient is known to fit in seven bits.
          if (!alu_neg) begin
            num <= alu_res;
            quot[div_count] <= 1'b1;
          end
          div_count <= div_count - 1'b1;
        end
        ST_CLAMP: begin
          if (quot > cfg.max_duty) begin
            duty <= cfg.max_duty;
          end else if (quot < cfg.min_duty) begin
            duty <= cfg.min_duty;
          end else begin
            duty <= quot;
          end
        end
        ST_LF_CMP: begin
          if (!alu_neg) begin
            pump_running <= 1'b0;
            switch_state <= 1'b0;
            duty <= '0;
            mode_q <= spvc_pkg::MODE_EXPIRED;
          end
        end
        ST_LF_DELTA: tmp <= spvc_pkg::alu_word_t'({2'b00, alu_res[31:0]});
        ST_LF_ACC: begin
          // The low-flow counter saturates rather than wrapping.
          low_flow_elapsed <= alu_res[32] ? '1 : alu_res[31:0];
          duty <= cfg.min_duty;
          mode_q <= spvc_pkg::MODE_LOW_FLOW;
        end
        ST_LVL_SCALE: begin
          if (mode_q == spvc_pkg::MODE_REGULATE || mode_q == spvc_pkg::MODE_LOW_FLOW ||
              mode_q == spvc_pkg::MODE_EXPIRED) begin
            last_run_time <= now;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            pump_on <= pump_running;
            switch_on <= switch_state;
            duty_percent <= duty;
            valve_level <= prod[spvc_pkg::LevelShift +: spvc_pkg::LevelW];
            mode <= mode_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- tb/tb_solar_pump_valve_controller_unit.sv -----
// Self-checking testbench for the solar pump and valve controller unit.
// Drives directed and random sensor words, predicts every result word and
// checks it. Depends on spvc_pkg and solar_pump_valve_controller_unit.
`timescale 1ns / 100ps

module tb_solar_pump_valve_controller_unit;

  localparam int DirCount = 20;
  localparam int StallLimit = 3000;
  localparam int DrainCycles = 30;
  localparam int HoldCycles = 400;
  localparam int HoldAfterWords = 60;
  localparam int GuardRise = 60;
  localparam int LevelNum = 255;
  localparam int PercentFull = 100;
  localparam logic [spvc_pkg::CfgIndexW-1:0] RegUnused = 3'd7;
  localparam logic signed [spvc_pkg::TempW-1:0] TMax = 16'sh7fff;
  localparam logic signed [spvc_pkg::TempW-1:0] TMin = 16'sh8000;

  typedef struct packed {
    logic signed [spvc_pkg::TempW-1:0] col;
    logic signed [spvc_pkg::TempW-1:0] tank;
    logic signed [spvc_pkg::TempW-1:0] inl;
    logic signed [spvc_pkg::TempW-1:0] outl;
    logic [spvc_pkg::TimeW-1:0]        secs;
  } sample_t;

  typedef struct packed {
    logic                        pump;
    logic                        sw;
    logic [spvc_pkg::DutyW-1:0]  duty;
    logic [spvc_pkg::LevelW-1:0] level;
    spvc_pkg::mode_t             md;
  } valve_result_t;

  typedef struct packed {
    sample_t       smp;
    logic          known;
    valve_result_t res;
  } stim_row_t;

  localparam valve_result_t NoRes = '{1'b0, 1'b0, 7'd0, 8'd0, spvc_pkg::MODE_CRITICAL};
  localparam valve_result_t StopRes = '{1'b0, 1'b0, 7'd0, 8'd0, spvc_pkg::MODE_CRITICAL};
  localparam valve_result_t GuardRes = '{1'b0, 1'b0, 7'd0, 8'd0, spvc_pkg::MODE_REVERSE};
  localparam valve_result_t FullRes = '{1'b1, 1'b1, 7'd100, 8'd255, spvc_pkg::MODE_REGULATE};

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [spvc_pkg::TempW-1:0] collector_temp = '0;
  logic signed [spvc_pkg::TempW-1:0] tank_temp = '0;
  logic signed [spvc_pkg::TempW-1:0] inlet_temp = '0;
  logic signed [spvc_pkg::TempW-1:0] outlet_temp = '0;
  logic [spvc_pkg::TimeW-1:0] time_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pump_on;
  logic switch_on;
  logic [spvc_pkg::DutyW-1:0] duty_percent;
  logic [spvc_pkg::LevelW-1:0] valve_level;
  logic [2:0] mode;
  logic cfg_write = 1'b0;
  logic [spvc_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [spvc_pkg::CfgDataW-1:0] cfg_data = '0;

  solar_pump_valve_controller_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .collector_temp (collector_temp),
    .tank_temp      (tank_temp),
    .inlet_temp     (inlet_temp),
    .outlet_temp    (outlet_temp),
    .time_seconds   (time_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pump_on        (pump_on),
    .switch_on      (switch_on),
    .duty_percent   (duty_percent),
    .valve_level    (valve_level),
    .mode           (mode),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predictor state, kept in step with the accepted words.
  spvc_pkg::cfg_t cfg_shadow;
  bit st_pump;
  bit st_switch;
  int st_duty;
  logic [spvc_pkg::TimeW-1:0] st_elapsed;
  logic [spvc_pkg::TimeW-1:0] st_last;

  valve_result_t pending_valve_words[$];
  int faults = 0;
  int words_checked = 0;
  int unsigned send_idle = 22;
  int unsigned recv_idle = 82;
  int quiet_cycles = 0;
  logic [spvc_pkg::TimeW-1:0] clock_secs = '0;

  // Collector, tank, inlet, outlet, seconds; then whether the result is typed in.
  stim_row_t directed_rows [DirCount] = '{
    '{'{TMax, TMin, 16'sd0, 16'sd0, 32'd0}, 1'b1, StopRes},
    '{'{16'sd8999, TMax, 16'sd0, 16'sd0, 32'd1}, 1'b1, StopRes},
    '{'{16'sd9000, 16'sd6000, 16'sd0, 16'sd0, 32'd2}, 1'b1, StopRes},
    '{'{16'sd0, 16'sd6000, 16'sd159, 16'sd100, 32'd3}, 1'b1, GuardRes},
    '{'{16'sd0, 16'sd0, 16'sd160, 16'sd100, 32'd4}, 1'b0, NoRes},
    '{'{16'sd2000, 16'sd0, 16'sd2000, 16'sd0, 32'd10}, 1'b1, FullRes},
    '{'{16'sd1000, 16'sd0, 16'sd1000, 16'sd100, 32'd20}, 1'b0, NoRes},
    '{'{16'sd900, 16'sd0, 16'sd900, 16'sd600, 32'd25}, 1'b0, NoRes},
    '{'{16'sd1600, 16'sd0, 16'sd1598, 16'sd100, 32'd30}, 1'b0, NoRes},
    '{'{-16'sd3, 16'sd0, 16'sd0, -16'sd1000, 32'd35}, 1'b0, NoRes},
    '{'{16'sd100, 16'sd0, 16'sd100, 16'sd100, 32'd40}, 1'b0, NoRes},
    '{'{16'sd100, 16'sd0, 16'sd100, 16'sd100, 32'd39}, 1'b0, NoRes},
    '{'{16'sd100, 16'sd0, 16'sd100, 16'sd100, 32'd50}, 1'b0, NoRes},
    '{'{16'sd100, 16'sd0, 16'sd100, 16'sd100, 32'hFFFF_FFF0}, 1'b0, NoRes},
    '{'{16'sd2000, 16'sd0, 16'sd2000, 16'sd0, 32'hFFFF_FFF8}, 1'b1, FullRes},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0010}, 1'b0, NoRes},
    '{'{TMin, TMin, TMax, TMin, 32'd17}, 1'b0, NoRes},
    '{'{TMin, 16'sd0, TMin, TMax, 32'd18}, 1'b1, GuardRes},
    '{'{16'sd500, 16'sd0, 16'sd1300, 16'sd400, 32'd19}, 1'b0, NoRes},
    '{'{16'sd8999, 16'sd6000, TMax, TMin, 32'hFFFF_FFFF}, 1'b1, FullRes}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [spvc_pkg::TempW-1:0] clip16(input int v);
    if (v > 32767) return TMax;
    if (v < -32768) return TMin;
    return v[spvc_pkg::TempW-1:0];
  endfunction

  function automatic logic [spvc_pkg::DutyW-1:0] duty_clamp(
      input logic [spvc_pkg::CfgDataW-1:0] data);
    return (data[spvc_pkg::DutyW-1:0] > spvc_pkg::DutyLimit) ?
           spvc_pkg::DutyLimit : data[spvc_pkg::DutyW-1:0];
  endfunction

  function automatic void apply_reg(input logic [spvc_pkg::CfgIndexW-1:0] idx,
                                    input logic [spvc_pkg::CfgDataW-1:0] data);
    case (idx)
      spvc_pkg::RegCritical:  cfg_shadow.critical_collector_temp = data;
      spvc_pkg::RegTankLimit: cfg_shadow.tank_limit_temp = data;
      spvc_pkg::RegStartRise: cfg_shadow.start_rise = data;
      spvc_pkg::RegLowRise:   cfg_shadow.low_rise = data;
      spvc_pkg::RegFullRise:  cfg_shadow.full_rise = data;
      spvc_pkg::RegMinDuty:   cfg_shadow.min_duty = duty_clamp(data);
      spvc_pkg::RegMaxDuty:   cfg_shadow.max_duty = duty_clamp(data);
      default: ;
    endcase
  endfunction

  function automatic void reset_valve_state();
    cfg_shadow.critical_collector_temp = 16'sd9000;
    cfg_shadow.tank_limit_temp = 16'sd6000;
    cfg_shadow.start_rise = 16'sd800;
    cfg_shadow.low_rise = 16'sd300;
    cfg_shadow.full_rise = 16'sd1500;
    cfg_shadow.min_duty = 7'd20;
    cfg_shadow.max_duty = 7'd100;
    st_pump = 1'b0;
    st_switch = 1'b0;
    st_duty = 0;
    st_elapsed = '0;
    st_last = '0;
  endfunction

  function automatic valve_result_t predict_valve_word(input sample_t smp);
    valve_result_t res;
    int col, tank, inl, outl, avg, rise_dt;
    int crit, tlim, srise, lrise, frise, dmin, dmax;
    longint span, num, q;
    logic [spvc_pkg::TimeW-1:0] delta, acc;
    spvc_pkg::mode_t md;
    col = smp.col;
    tank = smp.tank;
    inl = smp.inl;
    outl = smp.outl;
    crit = cfg_shadow.critical_collector_temp;
    tlim = cfg_shadow.tank_limit_temp;
    srise = cfg_shadow.start_rise;
    lrise = cfg_shadow.low_rise;
    frise = cfg_shadow.full_rise;
    dmin = cfg_shadow.min_duty;
    dmax = cfg_shadow.max_duty;
    if (col >= crit || tank > tlim) begin
      st_pump = 1'b0;
      st_switch = 1'b0;
      st_duty = 0;
      md = spvc_pkg::MODE_CRITICAL;
    end else if (outl > col && (inl - outl) < GuardRise) begin
      st_pump = 1'b0;
      st_switch = 1'b0;
      st_duty = 0;
      md = spvc_pkg::MODE_REVERSE;
    end else begin
      if ((col - outl) > srise) begin
        st_pump = 1'b1;
        st_switch = 1'b1;
        st_elapsed = '0;
      end
      // Integer division truncates toward zero, as the average requires.
      avg = (col + inl) / 2;
      rise_dt = avg - outl;
      if (rise_dt >= lrise) begin
        md = spvc_pkg::MODE_REGULATE;
        if (st_pump) begin
          if (rise_dt >= frise) begin
            st_duty = dmax;
          end else begin
            span = longint'(frise) - longint'(lrise);
            if (span == 0) begin
              q = dmax;
            end else begin
              num = longint'(dmin) * span
                    + (longint'(dmax) - longint'(dmin)) * (longint'(rise_dt) - longint'(lrise));
              q = num / span;
            end
            if (q > dmax) st_duty = dmax;
            else if (q < dmin) st_duty = dmin;
            else st_duty = int'(q);
          end
        end
      end else if (st_elapsed < spvc_pkg::LowFlowSeconds) begin
        delta = smp.secs - st_last;
        acc = st_elapsed + delta;
        st_elapsed = (acc < st_elapsed) ? '1 : acc;
        st_duty = dmin;
        md = spvc_pkg::MODE_LOW_FLOW;
      end else begin
        st_pump = 1'b0;
        st_switch = 1'b0;
        st_duty = 0;
        md = spvc_pkg::MODE_EXPIRED;
      end
      st_last = smp.secs;
    end
    res.pump = st_pump;
    res.sw = st_switch;
    res.duty = st_duty[spvc_pkg::DutyW-1:0];
    res.level = 8'((st_duty * LevelNum) / PercentFull);
    res.md = md;
    return res;
  endfunction

  // Random words: mostly well-formed loop readings around the current
  // thresholds, with stops, reverse-flow cases and raw noise mixed in.
  function automatic sample_t random_sample();
    sample_t smp;
    int kind, pick, c, o, i, tk, dt, lo, hi, crit, tlim, srise, lrise, frise;
    logic [31:0] r0, r1, r2, r3;
    crit = cfg_shadow.critical_collector_temp;
    tlim = cfg_shadow.tank_limit_temp;
    srise = cfg_shadow.start_rise;
    lrise = cfg_shadow.low_rise;
    frise = cfg_shadow.full_rise;
    pick = $urandom_range(0, 99);
    if (pick < 80) clock_secs = clock_secs + $urandom_range(0, 240);
    else if (pick < 90) clock_secs = clock_secs + $urandom_range(0, 4000);
    else if (pick < 95) clock_secs = clock_secs - $urandom_range(0, 3);
    else clock_secs = $urandom();
    smp.secs = clock_secs;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      r0 = $urandom();
      r1 = $urandom();
      r2 = $urandom();
      r3 = $urandom();
      smp.col = r0[spvc_pkg::TempW-1:0];
      smp.tank = r1[spvc_pkg::TempW-1:0];
      smp.inl = r2[spvc_pkg::TempW-1:0];
      smp.outl = r3[spvc_pkg::TempW-1:0];
      return smp;
    end
    if (kind < 16) begin
      c = int'($urandom_range(0, 2000));
      tk = tlim - int'($urandom_range(1, 500));
      if ($urandom_range(0, 1) != 0) c = crit + int'($urandom_range(0, 40)) - 1;
      else tk = tlim + 1 + int'($urandom_range(0, 40));
      o = c - int'($urandom_range(0, 2000));
      i = o + int'($urandom_range(0, 2000)) - 1000;
    end else if (kind < 26) begin
      c = int'($urandom_range(0, 8000)) - 1000;
      o = c + int'($urandom_range(0, 200));
      i = o + int'($urandom_range(0, 120)) - 60;
      tk = tlim - int'($urandom_range(1, 3000));
    end else begin
      o = int'($urandom_range(0, 6000)) - 1000;
      lo = ((lrise < frise) ? lrise : frise) - 600;
      hi = ((lrise < frise) ? frise : lrise) + 600;
      dt = lo + int'($urandom_range(0, hi - lo));
      c = o + srise + int'($urandom_range(0, 800)) - 400;
      i = 2 * (o + dt) - c + int'($urandom_range(0, 1));
      tk = tlim - int'($urandom_range(0, 3000));
    end
    smp.col = clip16(c);
    smp.tank = clip16(tk);
    smp.inl = clip16(i);
    smp.outl = clip16(o);
    return smp;
  endfunction

  task automatic send_word(input sample_t smp, input logic known, input valve_result_t typed);
    valve_result_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    collector_temp <= smp.col;
    tank_temp <= smp.tank;
    inlet_temp <= smp.inl;
    outlet_temp <= smp.outl;
    time_seconds <= smp.secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_valve_word(smp);
    pending_valve_words.push_back(known ? typed : want);
  endtask

  task automatic write_reg(input logic [spvc_pkg::CfgIndexW-1:0] idx,
                           input logic [spvc_pkg::CfgDataW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_valve_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic configure_segment(input int seg);
    logic [spvc_pkg::CfgDataW-1:0] v_crit, v_tank, v_start, v_low, v_full, v_min, v_max;
    int lowv;
    case (seg)
      0: begin
        v_crit = 16'd9000;
        v_tank = 16'd6000;
        v_start = 16'd800;
        v_low = 16'd300;
        v_full = 16'd1500;
        v_min = 16'd20;
        v_max = 16'd100;
      end
      2: begin
        v_crit = 16'h7fff;
        v_tank = 16'h7fff;
        v_start = 16'h8000;
        v_low = 16'h8000;
        v_full = 16'h7fff;
        v_min = 16'hffff;
        v_max = 16'h0000;
      end
      3: begin
        v_crit = 16'h8000;
        v_tank = 16'h8000;
        v_start = 16'h7fff;
        v_low = 16'h7fff;
        v_full = 16'h8000;
        v_min = 16'h0000;
        v_max = 16'd101;
      end
      4: begin
        v_crit = 16'($urandom());
        v_tank = 16'($urandom());
        v_start = 16'($urandom());
        v_low = 16'($urandom());
        v_full = 16'($urandom());
        v_min = 16'($urandom());
        v_max = 16'($urandom());
      end
      default: begin
        v_crit = 16'(6000 + $urandom_range(0, 6000));
        v_tank = 16'(4000 + $urandom_range(0, 4000));
        v_start = 16'(200 + $urandom_range(0, 1300));
        lowv = int'($urandom_range(0, 800)) - 200;
        v_low = 16'(lowv);
        v_full = 16'(lowv + 1 + int'($urandom_range(0, 2000)));
        v_min = 16'($urandom_range(0, 60));
        v_max = 16'($urandom_range(40, 100));
      end
    endcase
    write_reg(spvc_pkg::RegCritical, v_crit);
    write_reg(spvc_pkg::RegTankLimit, v_tank);
    write_reg(spvc_pkg::RegStartRise, v_start);
    write_reg(spvc_pkg::RegLowRise, v_low);
    write_reg(spvc_pkg::RegFullRise, v_full);
    write_reg(spvc_pkg::RegMinDuty, v_min);
    write_reg(spvc_pkg::RegMaxDuty, v_max);
    // A write to the spare index must leave every register as it was.
    if (seg == 2 || seg == 4) write_reg(RegUnused, 16'($urandom()));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  task automatic check_valve_word();
    valve_result_t want;
    if (pending_valve_words.size() == 0) begin
      $error("result word arrived with nothing expected");
      faults++;
    end else begin
      want = pending_valve_words.pop_front();
      check_field("pump_on", {7'd0, want.pump}, {7'd0, pump_on});
      check_field("switch_on", {7'd0, want.sw}, {7'd0, switch_on});
      check_field("duty_percent", {1'b0, want.duty}, {1'b0, duty_percent});
      check_field("valve_level", want.level, valve_level);
      check_field("mode", {5'd0, want.md}, {5'd0, mode});
    end
    words_checked++;
  endtask

  // Receiver: checks each accepted word, then decides the next ready. Once,
  // it holds off for a long stretch so that the block backs up to its input.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_valve_word();
      if (!hold_done && words_checked >= HoldAfterWords) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int seg_words [7];
    seg_words = '{120, 120, 100, 30, 100, 140, 140};
    reset_valve_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int row = 0; row < DirCount; row++) begin
      send_word(directed_rows[row].smp, directed_rows[row].known, directed_rows[row].res);
    end
    for (int seg = 0; seg < 7; seg++) begin
      drain_words();
      configure_segment(seg);
      if (seg >= 5) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (seg >= 2) begin
        send_idle = 82;
        recv_idle = 22;
      end
      for (int n = 0; n < seg_words[seg]; n++) send_word(random_sample(), 1'b0, NoRes);
    end
    drain_words();
    if (faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
